// File: hdl/pwlru_pkg.sv
`timescale 1ns / 1ps

package pwlru_pkg;

    // Table geometry
    localparam int ENTRIES   = 16;
    localparam int PAGE_BITS = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int AGE_W     = IDX_W;

    // Port field widths
    localparam int ID_W   = 32;
    localparam int SLOT_W = 4;

    // Rank of the least recently used entry in a full table
    localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(ENTRIES - 1);

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [AGE_W-1:0]     age_t;
    typedef logic [PAGE_BITS-1:0] page_t;
    typedef age_t [ENTRIES-1:0]   age_arr_t;

    // Update order from the scan sequencer to the rank store
    typedef struct packed {
        logic en;
        logic hit;
        idx_t slot;
        age_t hit_age;
    } commit_t;

    // Eviction outcome of one item
    typedef struct packed {
        logic  evicted;
        page_t evict_page;
    } evict_t;

endpackage

// File: hdl/pwlru_ram.sv
`timescale 1ns / 1ps

module pwlru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/pwlru_rank.sv
`timescale 1ns / 1ps

module pwlru_rank (
    input  logic               clk,
    input  logic               rst_n,
    input  pwlru_pkg::commit_t cmd,
    output logic [pwlru_pkg::ENTRIES-1:0] valid,
    output pwlru_pkg::age_arr_t           age
);

    logic [pwlru_pkg::ENTRIES-1:0] valid_reg;
    logic [pwlru_pkg::ENTRIES-1:0] valid_next;
    pwlru_pkg::age_arr_t           age_reg;
    pwlru_pkg::age_arr_t           age_next;

    // Update every entry's valid bit and recency rank in parallel
    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        if (cmd.en)
        begin
            for (int i = 0; i < pwlru_pkg::ENTRIES; i++)
            begin
                if (pwlru_pkg::IDX_W'(i) == cmd.slot)
                begin
                    valid_next[i] = 1'b1;
                    age_next[i]   = '0;
                end
                else if (valid_reg[i] && (!cmd.hit || age_reg[i] < cmd.hit_age))
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    assign valid = valid_reg;
    assign age   = age_reg;

`ifndef SYNTHESIS
    // A committed slot is valid and most recent afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.en |=> valid_reg[$past(cmd.slot)] && age_reg[$past(cmd.slot)] == '0)
        else $error("committed slot not valid with rank zero");

    // Valid bits never drop
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) >= $countones($past(valid_reg)))
        else $error("valid entry lost");
`endif

endmodule

// File: hdl/pwlru_scan.sv
`timescale 1ns / 1ps

module pwlru_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pwlru_pkg::page_t              page,
    output pwlru_pkg::idx_t               ram_raddr,
    input  pwlru_pkg::page_t              ram_rdata,
    input  logic [pwlru_pkg::ENTRIES-1:0] valid,
    input  pwlru_pkg::age_arr_t           age,
    output pwlru_pkg::commit_t            cmd,
    output pwlru_pkg::evict_t             evict
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    pwlru_pkg::idx_t   cnt_reg, cnt_next;
    logic              cmp_en_reg, cmp_en_next;
    pwlru_pkg::idx_t   cmp_idx_reg, cmp_idx_next;
    logic              found_reg, found_next;
    pwlru_pkg::idx_t   hit_slot_reg, hit_slot_next;
    pwlru_pkg::age_t   hit_age_reg, hit_age_next;
    logic              free_reg, free_next;
    pwlru_pkg::idx_t   free_slot_reg, free_slot_next;
    pwlru_pkg::idx_t   lru_slot_reg, lru_slot_next;
    pwlru_pkg::page_t  lru_page_reg, lru_page_next;
    logic              cur_valid;
    pwlru_pkg::age_t   cur_age;

    // Entry under comparison, the read address of the previous cycle
    assign cur_valid = valid[cmp_idx_reg];
    assign cur_age   = age[cmp_idx_reg];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmp_en_next    = cmp_en_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        hit_slot_next  = hit_slot_reg;
        hit_age_next   = hit_age_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        lru_slot_next  = lru_slot_reg;
        lru_page_next  = lru_page_reg;

        // Sequence the walk over all entries
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next    = ST_SCAN;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    free_next     = 1'b0;
                    lru_slot_next = '0;
                    lru_page_next = '0;
                end
            end
            ST_SCAN:
            begin
                cnt_next     = cnt_reg + 1'b1;
                cmp_en_next  = 1'b1;
                cmp_idx_next = cnt_reg;
                if (cnt_reg == pwlru_pkg::IDX_LAST)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                cmp_en_next = 1'b0;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next  = ST_IDLE;
                cmp_en_next = 1'b0;
            end
        endcase

        // Compare one entry: first match, first free slot, oldest entry
        if (cmp_en_reg)
        begin
            if (!found_reg && cur_valid && ram_rdata == page)
            begin
                found_next    = 1'b1;
                hit_slot_next = cmp_idx_reg;
                hit_age_next  = cur_age;
            end
            if (!free_reg && !cur_valid)
            begin
                free_next      = 1'b1;
                free_slot_next = cmp_idx_reg;
            end
            if (cur_valid && cur_age == pwlru_pkg::AGE_OLDEST)
            begin
                lru_slot_next = cmp_idx_reg;
                lru_page_next = ram_rdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            cmp_en_reg <= 1'b0;
            found_reg  <= 1'b0;
            free_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cmp_en_reg <= cmp_en_next;
            found_reg  <= found_next;
            free_reg   <= free_next;
        end
    end

    // Hold scan payload
    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        hit_slot_reg  <= hit_slot_next;
        hit_age_reg   <= hit_age_next;
        free_slot_reg <= free_slot_next;
        lru_slot_reg  <= lru_slot_next;
        lru_page_reg  <= lru_page_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign ram_raddr = cnt_reg;

    // Pick the slot: hit, else lowest free, else least recently used
    always_comb
    begin
        cmd.en      = (state_reg == ST_COMMIT);
        cmd.hit     = found_reg;
        cmd.hit_age = hit_age_reg;
        if (found_reg)
        begin
            cmd.slot = hit_slot_reg;
        end
        else if (free_reg)
        begin
            cmd.slot = free_slot_reg;
        end
        else
        begin
            cmd.slot = lru_slot_reg;
        end
        evict.evicted    = !found_reg && !free_reg;
        evict.evict_page = lru_page_reg;
    end

endmodule

// File: hdl/page_worker_lru_table_unit.sv
`timescale 1ns / 1ps

// Page-to-worker LRU table, fully associative, 16 entries.
// Request channel: drive page_id and req_type with start high; the item is
// taken at a rising edge where start is high and busy is low. busy stays high
// while the item is looked up and the table is updated.
// Result channel: done is high for exactly one cycle with slot, hit, evicted,
// evicted_page, kind_out and page_out valid in that cycle. The receiver
// cannot stall; the result must be taken in that cycle.
// done rises once the walk over all entries and the commit are over. A new
// item can be taken from the cycle in which done is high, as busy is low
// then. The walk over the page store: one comparator checks one entry per
// cycle through a single RAM read port, behind the registered RAM read; a
// commit state then updates the table, and the result register then holds
// the item for the cycle in which done is high.
// Reset: all entries become free and all ranks zero; the page store itself
// is not cleared, as only valid entries are ever compared.
module page_worker_lru_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] page_id,
    input  logic        req_type,
    output logic        done,
    output logic [3:0]  slot,
    output logic        hit,
    output logic        evicted,
    output logic [31:0] evicted_page,
    output logic        kind_out,
    output logic [31:0] page_out
);

    logic                              accept;
    logic [pwlru_pkg::ID_W-1:0]        req_page_reg;
    logic                              req_kind_reg;
    pwlru_pkg::idx_t                   ram_raddr;
    pwlru_pkg::page_t                  ram_rdata;
    logic [pwlru_pkg::ENTRIES-1:0]     valid;
    pwlru_pkg::age_arr_t               age;
    pwlru_pkg::commit_t                cmd;
    pwlru_pkg::evict_t                 evict;
    logic                              done_reg;
    logic [pwlru_pkg::SLOT_W-1:0]      slot_reg;
    logic                              hit_reg;
    logic                              evicted_reg;
    logic [pwlru_pkg::ID_W-1:0]        evicted_page_reg;
    logic                              kind_out_reg;
    logic [pwlru_pkg::ID_W-1:0]        page_out_reg;

    assign accept = start && !busy;

    // Latch the request item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_page_reg <= page_id;
            req_kind_reg <= req_type;
        end
    end

    pwlru_ram #(
        .WIDTH (pwlru_pkg::PAGE_BITS),
        .DEPTH (pwlru_pkg::ENTRIES)
    ) u_page_ram (
        .clk   (clk),
        .we    (cmd.en && !cmd.hit),
        .waddr (cmd.slot),
        .wdata (pwlru_pkg::PAGE_BITS'(req_page_reg)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pwlru_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .page      (pwlru_pkg::PAGE_BITS'(req_page_reg)),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .valid     (valid),
        .age       (age),
        .cmd       (cmd),
        .evict     (evict)
    );

    pwlru_rank u_rank (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .valid (valid),
        .age   (age)
    );

    // Strobe the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.en;
        end
    end

    // Register the result item
    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            slot_reg     <= pwlru_pkg::SLOT_W'(cmd.slot);
            hit_reg      <= cmd.hit;
            evicted_reg  <= evict.evicted;
            kind_out_reg <= req_kind_reg;
            page_out_reg <= req_page_reg;
            if (evict.evicted)
            begin
                evicted_page_reg <= pwlru_pkg::ID_W'(evict.evict_page);
            end
            else
            begin
                evicted_page_reg <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign slot         = slot_reg;
    assign hit          = hit_reg;
    assign evicted      = evicted_reg;
    assign evicted_page = evicted_page_reg;
    assign kind_out     = kind_out_reg;
    assign page_out     = page_out_reg;

`ifndef SYNTHESIS
    // A result is only shown once the lookup is over
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A hit never evicts
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !evicted)
        else $error("hit reported with eviction");

    // An accepted item starts a lookup and no result follows at once
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted item did not start a lookup");
`endif

endmodule
